// ===== rtl/pmad_pkg.sv =====
// Shared types and constants for the priority min-area downscaler.
package pmad_pkg;

    localparam int MW_W     = 7;   // map side register width
    localparam int OW_W     = 8;   // output side register width
    localparam int AXIS_W   = 12;  // area origin and block base width
    localparam int SCR_W    = 13;  // screen coordinate width
    localparam int REM_W    = 9;   // remainder accumulator width
    localparam int COLOUR_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP   = 3'd5;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    localparam logic [COLOUR_W-1:0] COLOUR_UNMAPPED = 2'd3;
    localparam logic [AXIS_W-1:0]   BASE_MAX        = 12'hFFF;

    typedef struct packed {
        logic [MW_W-1:0] quotient;
        logic [OW_W-1:0] remainder;
    } t_div_res;

endpackage

// ===== rtl/pmad_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pmad_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pmad_pkg::MW_W-1:0] i_dividend,
    input  logic [pmad_pkg::OW_W-1:0] i_divisor,
    output logic                      o_done,
    output pmad_pkg::t_div_res        o_res
);

    localparam int CNT_W = $clog2(pmad_pkg::MW_W + 1);

    logic [pmad_pkg::MW_W-1:0] r_dvd;
    logic [pmad_pkg::OW_W-1:0] r_rem;
    logic [pmad_pkg::OW_W-1:0] r_dsr;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_run;
    logic                      r_done;

    logic [pmad_pkg::OW_W:0]   trial;
    logic [pmad_pkg::OW_W:0]   diff;
    logic                      ge;

    assign trial = {r_rem, r_dvd[pmad_pkg::MW_W-1]};
    assign ge    = trial >= {1'b0, r_dsr};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(pmad_pkg::MW_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_rem <= ge ? diff[pmad_pkg::OW_W-1:0] : trial[pmad_pkg::OW_W-1:0];
            r_dvd <= {r_dvd[pmad_pkg::MW_W-2:0], ge};
        end
    end

    assign o_done          = r_done;
    assign o_res.quotient  = r_dvd;
    assign o_res.remainder = r_rem;

endmodule

// ===== rtl/priority_min_area_downscaler.sv =====
// Priority map store with min-pooling downscale renderer.
//
//  channel   signals                                         direction
//  command   start, busy, i_action, i_cell_index,
//            i_cell_colour                                   in
//  result    o_valid, o_pixel_colour, o_screen_x,
//            o_screen_y, o_frame_last                        out
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,
//            i_cfg_data                                      in
//
// Cell write: the next item can follow at once.
// Render: busy through two 7-step divisions on the shared divider, block set-up, and a read
// of each map cell in the block on the single memory read port (no reads if it is empty).
// The result shows in the same cycle that busy drops, when a new item can already be taken.
// After reset a clearing pass writes every one of the MAP_SIDE_MAX^2 map cells
// (4096 at default) with busy high; config writes are taken only while busy is low.
// A result is held for exactly one cycle on o_valid; the receiver cannot stall.
module priority_min_area_downscaler #(
    parameter int MAP_SIDE_MAX = 64,
    parameter int OUT_SIDE_MAX = 255
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic [pmad_pkg::AXIS_W-1:0]     i_cell_index,
    input  logic [pmad_pkg::COLOUR_W-1:0]   i_cell_colour,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pmad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pmad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic [pmad_pkg::COLOUR_W-1:0]   o_pixel_colour,
    output logic [pmad_pkg::SCR_W-1:0]      o_screen_x,
    output logic [pmad_pkg::SCR_W-1:0]      o_screen_y,
    output logic                            o_frame_last
);

    localparam int STORE_DEPTH = MAP_SIDE_MAX * MAP_SIDE_MAX;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int MW_W = pmad_pkg::MW_W;
    localparam int OW_W = pmad_pkg::OW_W;
    localparam int AX_W = pmad_pkg::AXIS_W;
    localparam int SC_W = pmad_pkg::SCR_W;
    localparam int RM_W = pmad_pkg::REM_W;
    localparam int CL_W = pmad_pkg::COLOUR_W;
    localparam int PW   = 2 * MW_W + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DW0   = 4'd2;
    localparam logic [3:0] S_DW1   = 4'd3;
    localparam logic [3:0] S_DH0   = 4'd4;
    localparam logic [3:0] S_DH1   = 4'd5;
    localparam logic [3:0] S_PREP1 = 4'd6;
    localparam logic [3:0] S_PREP2 = 4'd7;
    localparam logic [3:0] S_SCAN  = 4'd8;
    localparam logic [3:0] S_DRAIN = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    function automatic logic [AX_W-1:0] sat_base(logic [SC_W-1:0] v);
        return (v > SC_W'(pmad_pkg::BASE_MAX)) ? pmad_pkg::BASE_MAX : v[AX_W-1:0];
    endfunction

    // configuration
    logic [MW_W-1:0] r_map_width, r_map_height;
    logic [OW_W-1:0] r_out_width, r_out_height;
    logic [AX_W-1:0] r_area_left, r_area_top;

    // control and traversal
    logic [3:0]      r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [OW_W-1:0] r_col, n_col, r_row, n_row;
    logic [RM_W-1:0] r_col_rem, n_col_rem, r_row_rem, n_row_rem;
    logic [AX_W-1:0] r_col_base, n_col_base, r_row_base, n_row_base;
    logic            r_row_ext, n_row_ext, r_ext, n_ext;
    logic            r_rd_v, n_rd_v;
    logic            r_o_valid, n_o_valid;

    // per-item working values
    logic [MW_W-1:0] r_qw, n_qw, r_qh, n_qh, r_side, n_side;
    logic [OW_W-1:0] r_rw, n_rw, r_rh, n_rh;
    logic [MW_W-1:0] r_i, n_i, r_j, n_j, r_imax, n_imax, r_jmax, n_jmax;
    logic [AW-1:0]   r_addr, n_addr, r_row_addr, n_row_addr;
    logic [CL_W-1:0] r_min, n_min;
    logic [CL_W-1:0] r_o_colour, n_o_colour;
    logic [SC_W-1:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic            r_o_last, n_o_last;

    // map store
    logic [CL_W-1:0] mem [STORE_DEPTH];
    logic [CL_W-1:0] r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [CL_W-1:0] mem_wdata;

    // combinational helpers
    logic            accept;
    logic [MW_W-1:0] mw, mh;
    logic [OW_W-1:0] ow, oh;
    logic            restart;
    logic [OW_W-1:0] p_col, p_row;
    logic [RM_W-1:0] p_col_rem, p_row_rem;
    logic [AX_W-1:0] p_col_base, p_row_base;
    logic            p_row_ext;
    logic [SC_W-1:0] jsum, isum;
    logic [MW_W-1:0] jlim, ilim;
    logic            empty;
    logic [2*MW_W-1:0] prod;
    logic [PW-1:0]   start_sum;
    logic            i_last, j_last;
    logic [OW_W-1:0] col_inc, row_inc;
    logic [SC_W-1:0] cb_sum, rb_sum;

    logic                      div_start;
    logic [MW_W-1:0]           div_dividend;
    logic [OW_W-1:0]           div_divisor;
    logic                      div_done;
    pmad_pkg::t_div_res        div_res;

    pmad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    assign div_start    = (r_state == S_DW0) || (r_state == S_DH0);
    assign div_dividend = (r_state == S_DH0) ? mh : mw;
    assign div_divisor  = (r_state == S_DH0) ? oh : ow;

    always_comb begin
        mw = (int'(r_map_width) > MAP_SIDE_MAX) ? MW_W'(MAP_SIDE_MAX) : r_map_width;
        mh = (int'(r_map_height) > MAP_SIDE_MAX) ? MW_W'(MAP_SIDE_MAX) : r_map_height;
        priority if (r_out_width == '0) begin
            ow = OW_W'(1);
        end else if (int'(r_out_width) > OUT_SIDE_MAX) begin
            ow = OW_W'(OUT_SIDE_MAX);
        end else begin
            ow = r_out_width;
        end
        priority if (r_out_height == '0) begin
            oh = OW_W'(1);
        end else if (int'(r_out_height) > OUT_SIDE_MAX) begin
            oh = OW_W'(OUT_SIDE_MAX);
        end else begin
            oh = r_out_height;
        end
    end

    always_comb begin
        restart    = (r_col >= ow) || (r_row >= oh);
        p_col      = restart ? '0 : r_col;
        p_row      = restart ? '0 : r_row;
        p_col_rem  = restart ? '0 : r_col_rem;
        p_row_rem  = restart ? '0 : r_row_rem;
        p_col_base = restart ? '0 : r_col_base;
        p_row_base = restart ? '0 : r_row_base;
        p_row_ext  = restart ? 1'b0 : r_row_ext;

        jsum  = SC_W'(r_row_base) + SC_W'(r_side) + SC_W'(r_row_ext);
        isum  = SC_W'(r_col_base) + SC_W'(r_side) + SC_W'(r_ext);
        jlim  = (jsum > SC_W'(mh)) ? mh : jsum[MW_W-1:0];
        ilim  = (isum > SC_W'(mw)) ? mw : isum[MW_W-1:0];
        empty = (SC_W'(r_row_base) >= SC_W'(jlim)) || (SC_W'(r_col_base) >= SC_W'(ilim));
        prod  = r_row_base[MW_W-1:0] * mw;
        start_sum = PW'(prod) + PW'(r_col_base[MW_W-1:0]);

        i_last = ({1'b0, r_i} + 8'd1) >= {1'b0, r_imax};
        j_last = ({1'b0, r_j} + 8'd1) >= {1'b0, r_jmax};

        col_inc = r_col + OW_W'(1);
        row_inc = r_row + OW_W'(1);
        cb_sum  = isum;
        rb_sum  = jsum;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = pmad_pkg::COLOUR_UNMAPPED;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (accept && i_action == pmad_pkg::ACT_WRITE
                     && int'(i_cell_index) < STORE_DEPTH) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(i_cell_index);
            mem_wdata = i_cell_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_col      = r_col;
        n_row      = r_row;
        n_col_rem  = r_col_rem;
        n_row_rem  = r_row_rem;
        n_col_base = r_col_base;
        n_row_base = r_row_base;
        n_row_ext  = r_row_ext;
        n_ext      = r_ext;
        n_qw       = r_qw;
        n_qh       = r_qh;
        n_rw       = r_rw;
        n_rh       = r_rh;
        n_side     = r_side;
        n_i        = r_i;
        n_j        = r_j;
        n_imax     = r_imax;
        n_jmax     = r_jmax;
        n_addr     = r_addr;
        n_row_addr = r_row_addr;
        n_min      = r_min;
        n_o_colour = r_o_colour;
        n_o_x      = r_o_x;
        n_o_y      = r_o_y;
        n_o_last   = r_o_last;
        n_o_valid  = 1'b0;
        n_rd_v     = (r_state == S_SCAN);

        if (r_rd_v && r_rdata < r_min) begin
            n_min = r_rdata;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_action == pmad_pkg::ACT_RENDER) begin
                    n_state = S_DW0;
                end
            end
            S_DW0: n_state = S_DW1;
            S_DW1: begin
                if (div_done) begin
                    n_qw    = div_res.quotient;
                    n_rw    = div_res.remainder;
                    n_state = S_DH0;
                end
            end
            S_DH0: n_state = S_DH1;
            S_DH1: begin
                if (div_done) begin
                    n_qh    = div_res.quotient;
                    n_rh    = div_res.remainder;
                    n_state = S_PREP1;
                end
            end
            S_PREP1: begin
                n_col      = p_col;
                n_row      = p_row;
                n_col_base = p_col_base;
                n_row_base = p_row_base;
                n_col_rem  = p_col_rem;
                n_row_rem  = p_row_rem;
                n_row_ext  = p_row_ext;
                if (p_col == '0) begin
                    n_col_base = '0;
                    n_col_rem  = '0;
                    n_row_ext  = 1'b0;
                    if (p_row_rem >= {1'b0, oh}) begin
                        n_row_rem = p_row_rem - {1'b0, oh};
                        n_row_ext = 1'b1;
                    end
                end
                n_ext = 1'b0;
                if (n_col_rem >= {1'b0, ow}) begin
                    n_col_rem = n_col_rem - {1'b0, ow};
                    n_ext     = 1'b1;
                end
                n_side  = (r_qw > r_qh) ? r_qw : r_qh;
                n_state = S_PREP2;
            end
            S_PREP2: begin
                n_imax     = ilim;
                n_jmax     = jlim;
                n_i        = r_col_base[MW_W-1:0];
                n_j        = r_row_base[MW_W-1:0];
                n_addr     = AW'(start_sum);
                n_row_addr = AW'(start_sum);
                n_min      = pmad_pkg::COLOUR_UNMAPPED;
                n_state    = empty ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                if (!i_last) begin
                    n_i    = r_i + MW_W'(1);
                    n_addr = r_addr + AW'(1);
                end else if (!j_last) begin
                    n_i        = r_col_base[MW_W-1:0];
                    n_j        = r_j + MW_W'(1);
                    n_row_addr = r_row_addr + AW'(mw);
                    n_addr     = r_row_addr + AW'(mw);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_FIN;
            S_FIN: begin
                n_o_valid  = 1'b1;
                n_o_colour = r_min;
                n_o_x      = SC_W'(r_area_left) + SC_W'(r_col);
                n_o_y      = SC_W'(r_area_top) + SC_W'(r_row);
                n_o_last   = 1'b0;
                n_col_rem  = r_col_rem + RM_W'(r_rw);
                n_col_base = sat_base(cb_sum);
                if (col_inc >= ow) begin
                    n_col      = '0;
                    n_row_rem  = r_row_rem + RM_W'(r_rh);
                    n_row_base = sat_base(rb_sum);
                    n_row      = row_inc;
                    if (row_inc >= oh) begin
                        n_o_last   = 1'b1;
                        n_row      = '0;
                        n_col_rem  = '0;
                        n_row_rem  = '0;
                        n_col_base = '0;
                        n_row_base = '0;
                        n_row_ext  = 1'b0;
                    end
                end else begin
                    n_col = col_inc;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_col_rem    <= '0;
            r_row_rem    <= '0;
            r_col_base   <= '0;
            r_row_base   <= '0;
            r_row_ext    <= 1'b0;
            r_ext        <= 1'b0;
            r_rd_v       <= 1'b0;
            r_o_valid    <= 1'b0;
            r_map_width  <= MW_W'(64);
            r_map_height <= MW_W'(64);
            r_out_width  <= OW_W'(32);
            r_out_height <= OW_W'(32);
            r_area_left  <= '0;
            r_area_top   <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_col      <= n_col;
            r_row      <= n_row;
            r_col_rem  <= n_col_rem;
            r_row_rem  <= n_row_rem;
            r_col_base <= n_col_base;
            r_row_base <= n_row_base;
            r_row_ext  <= n_row_ext;
            r_ext      <= n_ext;
            r_rd_v     <= n_rd_v;
            r_o_valid  <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pmad_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[MW_W-1:0];
                    pmad_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[MW_W-1:0];
                    pmad_pkg::CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data[OW_W-1:0];
                    pmad_pkg::CFG_OUT_HEIGHT: r_out_height <= i_cfg_data[OW_W-1:0];
                    pmad_pkg::CFG_AREA_LEFT:  r_area_left  <= i_cfg_data[AX_W-1:0];
                    pmad_pkg::CFG_AREA_TOP:   r_area_top   <= i_cfg_data[AX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_qw       <= n_qw;
        r_qh       <= n_qh;
        r_rw       <= n_rw;
        r_rh       <= n_rh;
        r_side     <= n_side;
        r_i        <= n_i;
        r_j        <= n_j;
        r_imax     <= n_imax;
        r_jmax     <= n_jmax;
        r_addr     <= n_addr;
        r_row_addr <= n_row_addr;
        r_min      <= n_min;
        r_o_colour <= n_o_colour;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_last   <= n_o_last;
    end

    assign o_valid        = r_o_valid;
    assign o_pixel_colour = r_o_colour;
    assign o_screen_x     = r_o_x;
    assign o_screen_y     = r_o_y;
    assign o_frame_last   = r_o_last;

endmodule
